// ===== design/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared word types, operation and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH_DEFAULT      = 16;
	localparam int DATA_WIDTH_DEFAULT = 32;
	localparam int WORD_W             = 32;
	localparam int OP_W               = 3;
	localparam int COUNT_W            = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_PEEK       = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic signed [WORD_W-1:0] value;
	} req_word_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] back_value;
		logic [COUNT_W-1:0]       entry_count;
		logic                     is_empty;
		logic                     is_full;
		status_t                  status;
	} rsp_word_t;

	typedef struct packed {
		logic [COUNT_W-1:0] entry_count;
		logic               is_empty;
		logic               is_full;
		status_t            status;
	} meta_t;

endpackage

// ===== design/dq_ram.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue slot memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module dq_ram #(
	parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  logic [DATA_WIDTH-1:0]      wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
	output logic [DATA_WIDTH-1:0]      rd_data_a,
	output logic [DATA_WIDTH-1:0]      rd_data_b
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

// ===== design/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue index control
// Holds the front index and entry count, decodes the operation, and
// produces the slot write, the two slot reads and the result flags.
// ----------------------------------------------------------------------------
module dq_ctrl #(
	parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [dq_pkg::OP_W-1:0]    op,
	output logic                       wr_en,
	output logic [$clog2(DEPTH)-1:0]   wr_addr,
	output logic [$clog2(DEPTH)-1:0]   rd_front_addr,
	output logic [$clog2(DEPTH)-1:0]   rd_back_addr,
	output logic                       fwd_front,
	output logic                       fwd_back,
	output dq_pkg::meta_t              meta
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 2;
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

	logic [AW-1:0]   front_q, front_nxt, front_dec, front_inc;
	logic [AW-1:0]   tail_slot, back_slot;
	logic [CW-1:0]   count_q, count_nxt;
	logic [SW-1:0]   tail_sum, back_sum;
	logic            full, empty, wr_hit;
	dq_pkg::status_t status;

	assign full      = (count_q == FULL_C);
	assign empty     = (count_q == '0);
	assign front_dec = (front_q == '0) ? LAST : front_q - AW'(1);
	assign front_inc = (front_q == LAST) ? '0 : front_q + AW'(1);
	assign tail_sum  = SW'(front_q) + SW'(count_q);
	assign tail_slot = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);

	always_comb begin
		front_nxt = front_q;
		count_nxt = count_q;
		wr_hit    = 1'b0;
		wr_addr   = tail_slot;
		status    = dq_pkg::ST_DONE;
		unique case (op)
			dq_pkg::OP_PUSH_BACK: begin
				if (full) begin
					status = dq_pkg::ST_OVERFLOW;
				end else begin
					wr_hit    = 1'b1;
					count_nxt = count_q + CW'(1);
				end
			end
			dq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					status = dq_pkg::ST_OVERFLOW;
				end else begin
					wr_hit    = 1'b1;
					wr_addr   = front_dec;
					front_nxt = front_dec;
					count_nxt = count_q + CW'(1);
				end
			end
			dq_pkg::OP_POP_BACK: begin
				if (empty) begin
					status = dq_pkg::ST_UNDERFLOW;
				end else begin
					count_nxt = count_q - CW'(1);
				end
			end
			dq_pkg::OP_POP_FRONT: begin
				if (empty) begin
					status = dq_pkg::ST_UNDERFLOW;
				end else begin
					front_nxt = front_inc;
					count_nxt = count_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign back_sum  = SW'(front_nxt) + SW'(count_nxt)
		- ((count_nxt != '0) ? SW'(1) : SW'(0));
	assign back_slot = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);

	assign wr_en         = accept & wr_hit;
	assign rd_front_addr = front_nxt;
	assign rd_back_addr  = back_slot;
	assign fwd_front     = wr_hit & (wr_addr == front_nxt);
	assign fwd_back      = wr_hit & (wr_addr == back_slot);

	assign meta.entry_count = dq_pkg::COUNT_W'(count_nxt);
	assign meta.is_empty    = (count_nxt == '0);
	assign meta.is_full     = (count_nxt == FULL_C);
	assign meta.status      = status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_nxt;
			count_q <= count_nxt;
		end
	end

endmodule

// ===== design/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded double-ended queue of signed words kept in a ring of slots.
// ----------------------------------------------------------------------------
// The block takes one request word per clock, unless req_stall holds it off,
// and returns one response word for each, in order, through the registered
// read of the slot memory and then the output register. The index and count
// update in the cycle a request is accepted, so the next request may follow
// at once; a pushed word that the same request must report is forwarded
// around the memory. Push into a full queue reports overflow, pop from an
// empty queue reports underflow, and an empty queue reports zero for both
// end values.
module double_ended_queue_core #(
	parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  dq_pkg::req_word_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output dq_pkg::rsp_word_t rsp
);

	localparam int AW = $clog2(DEPTH);

	logic                  accept, out_free, s1_adv;
	logic                  wr_en, fwd_front, fwd_back;
	logic [AW-1:0]         wr_addr, rd_front_addr, rd_back_addr;
	logic [DATA_WIDTH-1:0] wr_data, rd_front, rd_back;
	logic [DATA_WIDTH-1:0] front_sel, back_sel;
	dq_pkg::meta_t         meta;

	logic                  s1_valid_q;
	logic                  fwd_front_s1, fwd_back_s1;
	logic [DATA_WIDTH-1:0] wdata_s1;
	dq_pkg::meta_t         meta_s1;

	logic                  rsp_valid_q;
	dq_pkg::rsp_word_t     rsp_q, rsp_nxt;

	assign out_free  = ~rsp_valid_q | ~rsp_stall;
	assign s1_adv    = s1_valid_q & out_free;
	assign req_stall = s1_valid_q & ~out_free;
	assign accept    = req_valid & ~req_stall;
	assign wr_data   = DATA_WIDTH'(req.value);

	dq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.op           (req.op),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.rd_front_addr(rd_front_addr),
		.rd_back_addr (rd_back_addr),
		.fwd_front    (fwd_front),
		.fwd_back     (fwd_back),
		.meta         (meta)
	);

	dq_ram #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_ram (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (accept),
		.rd_addr_a(rd_front_addr),
		.rd_addr_b(rd_back_addr),
		.rd_data_a(rd_front),
		.rd_data_b(rd_back)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_front_s1 <= fwd_front;
			fwd_back_s1  <= fwd_back;
			wdata_s1     <= wr_data;
			meta_s1      <= meta;
		end
	end

	assign front_sel = fwd_front_s1 ? wdata_s1 : rd_front;
	assign back_sel  = fwd_back_s1 ? wdata_s1 : rd_back;

	always_comb begin
		rsp_nxt.front_value = meta_s1.is_empty ? '0 : dq_pkg::WORD_W'(signed'(front_sel));
		rsp_nxt.back_value  = meta_s1.is_empty ? '0 : dq_pkg::WORD_W'(signed'(back_sel));
		rsp_nxt.entry_count = meta_s1.entry_count;
		rsp_nxt.is_empty    = meta_s1.is_empty;
		rsp_nxt.is_full     = meta_s1.is_full;
		rsp_nxt.status      = meta_s1.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== design/dq_checker.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level checks of the queue core, attached by bind.
// ----------------------------------------------------------------------------
module dq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input dq_pkg::req_word_t req,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input dq_pkg::rsp_word_t rsp
);

	logic                       req_take, rsp_take;
	logic [2:0]                 pend_q;
	logic                       have_q;
	logic [dq_pkg::COUNT_W-1:0] last_count_q;

	assign req_take = req_valid & ~req_stall;
	assign rsp_take = rsp_valid & ~rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			have_q       <= 1'b0;
			last_count_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(req_take) - 3'(rsp_take);
			if (rsp_take) begin
				have_q       <= 1'b1;
				last_count_q <= rsp.entry_count;
			end
		end
	end

	// A response never appears without an outstanding request, and at most
	// two requests are in flight.
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q <= 3'd2) && (!rsp_valid || pend_q != 3'd0))
		else $error("response count does not match accepted requests");

	// A rejected push or an ignored pop leaves the count unchanged.
	a_count_kept: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && have_q && rsp.status != dq_pkg::ST_DONE
		|-> rsp.entry_count == last_count_q)
		else $error("failed operation changed the entry count");

	// Overflow is reported only when full and underflow only when empty.
	a_status_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status != dq_pkg::ST_OVERFLOW || rsp.is_full)
			&& (rsp.status != dq_pkg::ST_UNDERFLOW || rsp.is_empty))
		else $error("status code disagrees with queue flags");

	// A stalled response stays in place.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (.*);
